// ===== hw/rtl/tvs_pkg.sv =====
// ----------------------------------------------------------------------------
// tvs_pkg
// Shared beat types, register indexes and constants of the volume sampler.
// ----------------------------------------------------------------------------
package tvs_pkg;

  typedef struct packed {
    logic               func;
    logic [5:0]         cell_x;
    logic [5:0]         cell_y;
    logic [3:0]         cell_z;
    logic signed [15:0] voxel_value;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
  } tvs_cmd_t;

  typedef struct packed {
    logic signed [15:0] sample_value;
    logic               was_sample;
  } tvs_res_t;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  localparam logic [1:0] CFG_SIZE_X = 2'd0;
  localparam logic [1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [1:0] CFG_SIZE_Z = 2'd2;

  localparam logic [6:0] SIZE_X_RST = 7'd64;
  localparam logic [6:0] SIZE_Y_RST = 7'd64;
  localparam logic [4:0] SIZE_Z_RST = 5'd16;

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 8;

  // two remainder steps per stage over the integer part magnitude
  function automatic int mod_stages(input int frac_bits);
    int nw;
    nw = (frac_bits >= 15) ? 1 : 15 - frac_bits;
    return (nw + 1) / 2;
  endfunction

endpackage

// ===== hw/rtl/tvs_ram.sv =====
// ----------------------------------------------------------------------------
// tvs_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module tvs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/tvs_fifo.sv =====
// ----------------------------------------------------------------------------
// tvs_fifo
// Small first-word fall-through queue in flip-flops.
// ----------------------------------------------------------------------------
module tvs_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wp;
  logic [PW-1:0]    rp;
  logic [CW-1:0]    cnt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt == CW'(DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_pop) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

// ===== hw/rtl/tvs_wrap.sv =====
// ----------------------------------------------------------------------------
// tvs_wrap
// One axis: floor cell, floored remainder by (size - 1) through a
// shift-subtract pipeline, neighbor index and fraction weight.
// ----------------------------------------------------------------------------
module tvs_wrap #(
  parameter int MAX       = 64,
  parameter int FRAC_BITS = 8
) (
  input  logic                   clk,
  input  logic                   adv,
  input  logic [15:0]            pos,
  input  logic [6:0]             size,
  output logic [$clog2(MAX)-1:0] i0,
  output logic [$clog2(MAX)-1:0] i1,
  output logic [FRAC_BITS-1:0]   w
);
  import tvs_pkg::*;

  localparam int MW = $clog2(MAX);
  localparam int NS = mod_stages(FRAC_BITS);
  localparam int PW = 2 * NS;

  logic [8:0]           s9;
  logic [8:0]           sc;
  logic [MW-1:0]        m;
  logic [15:0]          nfull;
  logic [MW-1:0]        rem    [NS+1];
  logic [PW-1:0]        nb     [NS+1];
  logic                 neg    [NS+1];
  logic [FRAC_BITS-1:0] wt     [NS+1];
  logic [MW-1:0]        rem_n  [NS];
  logic [PW-1:0]        nb_n   [NS];
  logic [MW-1:0]        rl;

  // clamp the size into range, then modulus is size - 1
  always_comb begin
    s9 = {2'b00, size};
    if (s9 < 9'd2) begin
      sc = 9'd2;
    end else if (s9 > 9'(MAX)) begin
      sc = 9'(MAX);
    end else begin
      sc = s9;
    end
    m = MW'(sc - 9'd1);
  end

  // magnitude of floor for positive, of -floor-1 for negative
  assign nfull = (pos ^ {16{pos[15]}}) >> FRAC_BITS;

  always_comb begin
    logic [MW:0]   t;
    logic [MW-1:0] r;
    logic [PW-1:0] b;
    for (int k = 0; k < NS; k++) begin
      r = rem[k];
      b = nb[k];
      for (int j = 0; j < 2; j++) begin
        t = {r, b[PW-1]};
        if (t >= {1'b0, m}) begin
          t = t - {1'b0, m};
        end
        r = t[MW-1:0];
        b = b << 1;
      end
      rem_n[k] = r;
      nb_n[k]  = b;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0] <= '0;
      nb[0]  <= PW'(nfull);
      neg[0] <= pos[15];
      wt[0]  <= pos[FRAC_BITS-1:0];
      for (int k = 0; k < NS; k++) begin
        rem[k+1] <= rem_n[k];
        nb[k+1]  <= nb_n[k];
        neg[k+1] <= neg[k];
        wt[k+1]  <= wt[k];
      end
    end
  end

  assign rl = rem[NS];
  assign i0 = neg[NS] ? (m - MW'(1) - rl) : rl;
  assign i1 = (i0 == m - MW'(1)) ? '0 : i0 + MW'(1);
  assign w  = wt[NS];

endmodule

// ===== hw/rtl/tvs_front.sv =====
// ----------------------------------------------------------------------------
// tvs_front
// Accepts command beats, checks write cells, wraps sample positions on all
// three axes and hands finished items to the middle queue.
// ----------------------------------------------------------------------------
module tvs_front #(
  parameter int MAX_X     = 64,
  parameter int MAX_Y     = 64,
  parameter int MAX_Z     = 16,
  parameter int FRAC_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  tvs_pkg::tvs_cmd_t        cmd,
  input  logic [6:0]               size_x,
  input  logic [6:0]               size_y,
  input  logic [4:0]               size_z,
  output logic                     q_push,
  input  logic                     q_full,
  output logic                     o_sample,
  output logic                     o_ok,
  output logic [15:0]              o_data,
  output logic [$clog2(MAX_X)-1:0] o_x0,
  output logic [$clog2(MAX_X)-1:0] o_x1,
  output logic [$clog2(MAX_Y)-1:0] o_y0,
  output logic [$clog2(MAX_Y)-1:0] o_y1,
  output logic [$clog2(MAX_Z)-1:0] o_z0,
  output logic [$clog2(MAX_Z)-1:0] o_z1,
  output logic [FRAC_BITS-1:0]     o_wx,
  output logic [FRAC_BITS-1:0]     o_wy,
  output logic [FRAC_BITS-1:0]     o_wz
);
  import tvs_pkg::*;

  localparam int NS = mod_stages(FRAC_BITS);
  localparam int XW = $clog2(MAX_X);
  localparam int YW = $clog2(MAX_Y);
  localparam int ZW = $clog2(MAX_Z);

  logic          adv;
  logic          v    [NS+1];
  logic          smp  [NS+1];
  logic          ok   [NS+1];
  logic [15:0]   dat  [NS+1];
  logic [XW-1:0] cx   [NS+1];
  logic [YW-1:0] cy   [NS+1];
  logic [ZW-1:0] cz   [NS+1];
  logic          in_ok;
  logic [XW-1:0] x0;
  logic [YW-1:0] y0;
  logic [ZW-1:0] z0;

  assign adv    = !v[NS] || !q_full;
  assign full   = !adv;
  assign q_push = v[NS] && !q_full;

  assign in_ok = ({3'b000, cmd.cell_x} < 9'(MAX_X)) &&
                 ({3'b000, cmd.cell_y} < 9'(MAX_Y)) &&
                 ({5'b00000, cmd.cell_z} < 9'(MAX_Z));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NS; k++) begin
        v[k] <= 1'b0;
      end
    end else if (adv) begin
      v[0] <= push;
      for (int k = 0; k < NS; k++) begin
        v[k+1] <= v[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      smp[0] <= (cmd.func == FUNC_SAMPLE);
      ok[0]  <= in_ok;
      dat[0] <= cmd.voxel_value;
      cx[0]  <= XW'(cmd.cell_x);
      cy[0]  <= YW'(cmd.cell_y);
      cz[0]  <= ZW'(cmd.cell_z);
      for (int k = 0; k < NS; k++) begin
        smp[k+1] <= smp[k];
        ok[k+1]  <= ok[k];
        dat[k+1] <= dat[k];
        cx[k+1]  <= cx[k];
        cy[k+1]  <= cy[k];
        cz[k+1]  <= cz[k];
      end
    end
  end

  tvs_wrap #(.MAX(MAX_X), .FRAC_BITS(FRAC_BITS)) u_wrap_x (
    .clk (clk), .adv (adv), .pos (cmd.pos_x), .size (size_x),
    .i0 (x0), .i1 (o_x1), .w (o_wx)
  );

  tvs_wrap #(.MAX(MAX_Y), .FRAC_BITS(FRAC_BITS)) u_wrap_y (
    .clk (clk), .adv (adv), .pos (cmd.pos_y), .size (size_y),
    .i0 (y0), .i1 (o_y1), .w (o_wy)
  );

  tvs_wrap #(.MAX(MAX_Z), .FRAC_BITS(FRAC_BITS)) u_wrap_z (
    .clk (clk), .adv (adv), .pos (cmd.pos_z), .size ({2'b00, size_z}),
    .i0 (z0), .i1 (o_z1), .w (o_wz)
  );

  // writes carry their cell in the first-neighbor slot
  assign o_sample = smp[NS];
  assign o_ok     = ok[NS];
  assign o_data   = dat[NS];
  assign o_x0     = smp[NS] ? x0 : cx[NS];
  assign o_y0     = smp[NS] ? y0 : cy[NS];
  assign o_z0     = smp[NS] ? z0 : cz[NS];

endmodule

// ===== hw/rtl/tvs_back.sv =====
// ----------------------------------------------------------------------------
// tvs_back
// Issues voxel writes and the eight neighbor reads over four store copies, the
// x0 corners before the x1 corners, then blends along x, y and z and rounds to Q8.8.
// ----------------------------------------------------------------------------
module tvs_back #(
  parameter int MAX_X     = 64,
  parameter int MAX_Y     = 64,
  parameter int MAX_Z     = 16,
  parameter int FRAC_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_empty,
  output logic                     q_pop,
  input  logic                     q_sample,
  input  logic                     q_ok,
  input  logic [15:0]              q_data,
  input  logic [$clog2(MAX_X)-1:0] q_x0,
  input  logic [$clog2(MAX_X)-1:0] q_x1,
  input  logic [$clog2(MAX_Y)-1:0] q_y0,
  input  logic [$clog2(MAX_Y)-1:0] q_y1,
  input  logic [$clog2(MAX_Z)-1:0] q_z0,
  input  logic [$clog2(MAX_Z)-1:0] q_z1,
  input  logic [FRAC_BITS-1:0]     q_wx,
  input  logic [FRAC_BITS-1:0]     q_wy,
  input  logic [FRAC_BITS-1:0]     q_wz,
  output logic                     o_push,
  output tvs_pkg::tvs_res_t        o_res,
  input  logic                     res_pop
);
  import tvs_pkg::*;

  localparam int F     = FRAC_BITS;
  localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_X);
  localparam int YW    = $clog2(MAX_Y);
  localparam int ZW    = $clog2(MAX_Z);
  localparam int CW    = $clog2(OUT_DEPTH + 1);
  localparam int A1W   = 16 + F;
  localparam int A2W   = 16 + 2 * F;
  localparam int A3W   = 16 + 3 * F;
  localparam logic [F:0] ONE_W = (F + 1)'(1) << F;

  function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] x,
                                            input logic [YW-1:0] y,
                                            input logic [ZW-1:0] z);
    return AW'((AW'(z) * AW'(MAX_Y) + AW'(y)) * AW'(MAX_X) + AW'(x));
  endfunction

  logic          phase;
  logic [CW-1:0] cnt;
  logic          start;
  logic          issue;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr [4];
  logic [15:0]   rd      [4];
  logic [15:0]   lo      [4];

  logic          r1_v, r1_last, r1_s;
  logic [F-1:0]  r1_wx, r1_wy, r1_wz;
  logic          s2_v, s2_s;
  logic [A1W-1:0] a  [4];
  logic [F-1:0]  s2_wy, s2_wz;
  logic          s3_v, s3_s;
  logic [A2W-1:0] b0, b1;
  logic [F-1:0]  s3_wz;
  logic          s4_v, s4_s;
  logic [A3W-1:0] c;

  logic [F:0]     omx, omy, omz;
  logic [A1W:0]   a_sum [4];
  logic [A2W:0]   b0_sum, b1_sum;
  logic [A3W:0]   c_sum;
  logic [A3W:0]   rnd;
  logic [A3W-3*F:0] rq;
  logic [15:0]    rv;

  assign start = !q_empty && !phase && (cnt < CW'(OUT_DEPTH));
  assign issue = start || phase;
  assign q_pop = (start && !q_sample) || phase;

  assign wr_en   = start && !q_sample && q_ok;
  assign wr_addr = addr_of(q_x0, q_y0, q_z0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      cnt   <= '0;
    end else begin
      phase <= start && q_sample;
      cnt   <= cnt + CW'(start) - CW'(res_pop);
    end
  end

  // copy k serves the neighbor pair at y = k[0], z = k[1]
  for (genvar k = 0; k < 4; k++) begin : g_copy
    assign rd_addr[k] = addr_of(phase ? q_x1 : q_x0,
                                k[0] ? q_y1 : q_y0,
                                k[1] ? q_z1 : q_z0);
    tvs_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
      .clk     (clk),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (q_data),
      .rd_addr (rd_addr[k]),
      .rd_data (rd[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else begin
      r1_v <= issue;
      s2_v <= r1_v && r1_last;
      s3_v <= s2_v;
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    r1_last <= phase || !q_sample;
    r1_s    <= q_sample;
    r1_wx   <= q_wx;
    r1_wy   <= q_wy;
    r1_wz   <= q_wz;
    if (r1_v && r1_s && !r1_last) begin
      for (int k = 0; k < 4; k++) begin
        lo[k] <= rd[k];
      end
    end
  end

  // x blend on biased voxels
  always_comb begin
    omx = ONE_W - {1'b0, r1_wx};
    for (int k = 0; k < 4; k++) begin
      a_sum[k] = (A1W + 1)'(lo[k] ^ 16'h8000) * (A1W + 1)'(omx) +
                 (A1W + 1)'(rd[k] ^ 16'h8000) * (A1W + 1)'(r1_wx);
    end
  end

  always_ff @(posedge clk) begin
    s2_s  <= r1_s;
    s2_wy <= r1_wy;
    s2_wz <= r1_wz;
    for (int k = 0; k < 4; k++) begin
      a[k] <= a_sum[k][A1W-1:0];
    end
  end

  // y blend
  assign omy    = ONE_W - {1'b0, s2_wy};
  assign b0_sum = (A2W + 1)'(a[0]) * (A2W + 1)'(omy) +
                  (A2W + 1)'(a[1]) * (A2W + 1)'(s2_wy);
  assign b1_sum = (A2W + 1)'(a[2]) * (A2W + 1)'(omy) +
                  (A2W + 1)'(a[3]) * (A2W + 1)'(s2_wy);

  always_ff @(posedge clk) begin
    s3_s  <= s2_s;
    s3_wz <= s2_wz;
    b0    <= b0_sum[A2W-1:0];
    b1    <= b1_sum[A2W-1:0];
  end

  // z blend
  assign omz   = ONE_W - {1'b0, s3_wz};
  assign c_sum = (A3W + 1)'(b0) * (A3W + 1)'(omz) +
                 (A3W + 1)'(b1) * (A3W + 1)'(s3_wz);

  always_ff @(posedge clk) begin
    s4_s <= s3_s;
    c    <= c_sum[A3W-1:0];
  end

  // round half up, back to signed Q8.8
  assign rnd = {1'b0, c} + ((A3W + 1)'(1) << (3 * F - 1));
  assign rq  = rnd[A3W:3*F];
  assign rv  = rq[16] ? 16'hFFFF : rq[15:0];

  assign o_push             = s4_v;
  assign o_res.sample_value = s4_s ? signed'(rv ^ 16'h8000) : '0;
  assign o_res.was_sample   = s4_s;

endmodule

// ===== hw/rtl/trilinear_volume_sample.sv =====
// ----------------------------------------------------------------------------
// trilinear_volume_sample
// Voxel store with trilinear sampling at signed fixed-point positions.
//
// Command beats enter on push/full: a write beat stores one voxel, a sample
// beat blends the eight neighbors of a position. Every command gives one
// result beat on empty/pop, in command order (writes answer zero with
// was_sample low). Sizes are set on cfg_we/cfg_addr/cfg_data; the user
// must do so only while idle, the block itself does not enforce it. A write
// uses the store once; a sample's eight reads go over four store copies of
// one read port each, so it issues its x0 corners and then its x1 corners,
// and no new command issues in between. Writes sustain one result per
// cycle while the result queue has room. Reset clears the control state and
// sets the sizes to 64, 64 and 16; the store is not cleared and holds
// garbage until written. When pop stays low the result queue takes eight
// beats, then issue stops, the four-deep middle queue and the wrap pipeline
// fill, and full rises.
// ----------------------------------------------------------------------------
module trilinear_volume_sample #(
  parameter int MAX_X     = 64,
  parameter int MAX_Y     = 64,
  parameter int MAX_Z     = 16,
  parameter int FRAC_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  tvs_pkg::tvs_cmd_t cmd,
  output logic              empty,
  input  logic              pop,
  output tvs_pkg::tvs_res_t res,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_addr,
  input  logic [6:0]        cfg_data
);
  import tvs_pkg::*;

  localparam int XW   = $clog2(MAX_X);
  localparam int YW   = $clog2(MAX_Y);
  localparam int ZW   = $clog2(MAX_Z);
  localparam int F    = FRAC_BITS;
  localparam int MIDW = 18 + 2 * (XW + YW + ZW) + 3 * F;
  localparam int RESW = $bits(tvs_res_t);

  logic [6:0] size_x;
  logic [6:0] size_y;
  logic [4:0] size_z;

  logic            f_push, f_ok, f_sample;
  logic [15:0]     f_data;
  logic [XW-1:0]   f_x0, f_x1;
  logic [YW-1:0]   f_y0, f_y1;
  logic [ZW-1:0]   f_z0, f_z1;
  logic [F-1:0]    f_wx, f_wy, f_wz;
  logic            m_full, m_empty, m_pop;
  logic [MIDW-1:0] m_din, m_dout;

  logic            b_sample, b_ok;
  logic [15:0]     b_data;
  logic [XW-1:0]   b_x0, b_x1;
  logic [YW-1:0]   b_y0, b_y1;
  logic [ZW-1:0]   b_z0, b_z1;
  logic [F-1:0]    b_wx, b_wy, b_wz;

  logic            o_push;
  tvs_res_t        o_res;
  logic            o_full;
  logic [RESW-1:0] o_dout;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= SIZE_X_RST;
      size_y <= SIZE_Y_RST;
      size_z <= SIZE_Z_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SIZE_X: size_x <= cfg_data;
        CFG_SIZE_Y: size_y <= cfg_data;
        CFG_SIZE_Z: size_z <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  tvs_front #(
    .MAX_X (MAX_X), .MAX_Y (MAX_Y), .MAX_Z (MAX_Z), .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .cmd      (cmd),
    .size_x   (size_x),
    .size_y   (size_y),
    .size_z   (size_z),
    .q_push   (f_push),
    .q_full   (m_full),
    .o_sample (f_sample),
    .o_ok     (f_ok),
    .o_data   (f_data),
    .o_x0     (f_x0),
    .o_x1     (f_x1),
    .o_y0     (f_y0),
    .o_y1     (f_y1),
    .o_z0     (f_z0),
    .o_z1     (f_z1),
    .o_wx     (f_wx),
    .o_wy     (f_wy),
    .o_wz     (f_wz)
  );

  assign m_din = {f_sample, f_ok, f_data, f_x0, f_x1, f_y0, f_y1, f_z0, f_z1,
                  f_wx, f_wy, f_wz};

  tvs_fifo #(.WIDTH(MIDW), .DEPTH(MID_DEPTH)) u_mid (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .din   (m_din),
    .full  (m_full),
    .pop   (m_pop),
    .dout  (m_dout),
    .empty (m_empty)
  );

  assign {b_sample, b_ok, b_data, b_x0, b_x1, b_y0, b_y1, b_z0, b_z1,
          b_wx, b_wy, b_wz} = m_dout;

  tvs_back #(
    .MAX_X (MAX_X), .MAX_Y (MAX_Y), .MAX_Z (MAX_Z), .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (m_empty),
    .q_pop    (m_pop),
    .q_sample (b_sample),
    .q_ok     (b_ok),
    .q_data   (b_data),
    .q_x0     (b_x0),
    .q_x1     (b_x1),
    .q_y0     (b_y0),
    .q_y1     (b_y1),
    .q_z0     (b_z0),
    .q_z1     (b_z1),
    .q_wx     (b_wx),
    .q_wy     (b_wy),
    .q_wz     (b_wz),
    .o_push   (o_push),
    .o_res    (o_res),
    .res_pop  (pop && !empty)
  );

  // issue credit keeps this queue from overflowing
  tvs_fifo #(.WIDTH(RESW), .DEPTH(OUT_DEPTH)) u_out (
    .clk   (clk),
    .rst   (rst),
    .push  (o_push),
    .din   (o_res),
    .full  (o_full),
    .pop   (pop && !o_full ? pop : pop),
    .dout  (o_dout),
    .empty (empty)
  );

  assign res = tvs_res_t'(o_dout);

endmodule

// ===== tb/sv/tb_trilinear_volume_sample.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_trilinear_volume_sample
// Self-checking bench for the trilinear volume sampler. Voxel writes and
// sample commands go in, and a class keeps its own voxel copy and sizes and
// predicts each result beat with an exact blend rounded once. Every voxel
// that a sample reads is written first. The run steps through several size
// settings, including out-of-range ones, under varying idle and stall rates.
// ----------------------------------------------------------------------------
module tb_trilinear_volume_sample;
  import tvs_pkg::*;

  localparam int LAT_WAIT = 16;
  localparam int STALL_LIMIT = 5000;

  class volume_scoreboard;
    logic [15:0] voxels [65536];
    bit          written [65536];
    int          sx, sy, sz;
    tvs_res_t    pending_q[$];
    int          errors;

    function new();
      sx = SIZE_X_RST;
      sy = SIZE_Y_RST;
      sz = SIZE_Z_RST;
      errors = 0;
    endfunction

    function void set_size(logic [1:0] idx, logic [6:0] val);
      case (idx)
        CFG_SIZE_X: sx = int'(val);
        CFG_SIZE_Y: sy = int'(val);
        CFG_SIZE_Z: sz = int'(val[4:0]);
        default: ;
      endcase
    endfunction

    function int span(int s, int mx);
      if (s < 2) s = 2;
      if (s > mx) s = mx;
      return s - 1;
    endfunction

    function int wrap(int i, int m);
      int r;
      r = i % m;
      if (r < 0) r += m;
      return r;
    endfunction

    // index bit 0 picks x1, bit 1 y1, bit 2 z1
    function void corner_addrs(tvs_cmd_t c, output int a [8]);
      int mx, my, mz, fx, fy, fz;
      int xs [2];
      int ys [2];
      int zs [2];
      mx = span(sx, 64);
      my = span(sy, 64);
      mz = span(sz, 16);
      fx = int'(c.pos_x) >>> 8;
      fy = int'(c.pos_y) >>> 8;
      fz = int'(c.pos_z) >>> 8;
      xs[0] = wrap(fx, mx); xs[1] = wrap(fx + 1, mx);
      ys[0] = wrap(fy, my); ys[1] = wrap(fy + 1, my);
      zs[0] = wrap(fz, mz); zs[1] = wrap(fz + 1, mz);
      for (int k = 0; k < 8; k++)
        a[k] = (zs[k[2]] * 64 + ys[k[1]]) * 64 + xs[k[0]];
    endfunction

    function logic [15:0] blend(tvs_cmd_t c);
      int a [8];
      longint unsigned v [8];
      longint unsigned wx, wy, wz, r;
      longint unsigned ax [4];
      longint unsigned by [2];
      corner_addrs(c, a);
      for (int k = 0; k < 8; k++) v[k] = voxels[a[k]] ^ 16'h8000;
      wx = c.pos_x[7:0];
      wy = c.pos_y[7:0];
      wz = c.pos_z[7:0];
      for (int k = 0; k < 4; k++) ax[k] = v[2*k] * (256 - wx) + v[2*k+1] * wx;
      by[0] = ax[0] * (256 - wy) + ax[1] * wy;
      by[1] = ax[2] * (256 - wy) + ax[3] * wy;
      r = by[0] * (256 - wz) + by[1] * wz;
      r = (r + (64'd1 << 23)) >> 24;
      if (r > 65535) r = 65535;
      return r[15:0] ^ 16'h8000;
    endfunction

    function void note_cmd(tvs_cmd_t c);
      tvs_res_t e;
      int a;
      if (c.func == FUNC_WRITE) begin
        a = (int'(c.cell_z) * 64 + int'(c.cell_y)) * 64 + int'(c.cell_x);
        voxels[a] = c.voxel_value;
        written[a] = 1;
        e.sample_value = '0;
        e.was_sample = 1'b0;
      end else begin
        e.sample_value = blend(c);
        e.was_sample = 1'b1;
      end
      pending_q.push_back(e);
    endfunction

    function void check_res(tvs_res_t r);
      tvs_res_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, r);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (r.sample_value !== e.sample_value) begin
        $display("%0t: sample_value mismatch, expected %h actual %h",
                 $time, e.sample_value, r.sample_value);
        errors++;
      end
      if (r.was_sample !== e.was_sample) begin
        $display("%0t: was_sample mismatch, expected %b actual %b",
                 $time, e.was_sample, r.was_sample);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  tvs_cmd_t   cmd;
  logic       empty;
  logic       pop;
  tvs_res_t   res;
  logic       cfg_we;
  logic [1:0] cfg_addr;
  logic [6:0] cfg_data;

  volume_scoreboard sb;
  int send_idle;
  int recv_stall;
  int quiet_cycles;

  trilinear_volume_sample u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .cmd(cmd),
    .empty(empty), .pop(pop), .res(res),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // result side: check accepted beats, then pick pop for the next cycle
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) sb.check_res(res);
      pop <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic tvs_cmd_t rand_cmd();
    tvs_cmd_t c;
    c = $bits(tvs_cmd_t)'({$urandom, $urandom, $urandom});
    return c;
  endfunction

  task automatic send(tvs_cmd_t c);
    if ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    cmd <= c;
    push <= 1'b1;
    do @(posedge clk); while (full);
    sb.note_cmd(c);
  endtask

  task automatic write_voxel(int a, logic [15:0] val);
    tvs_cmd_t c;
    c = rand_cmd();
    c.func = FUNC_WRITE;
    c.cell_x = 6'(a % 64);
    c.cell_y = 6'((a / 64) % 64);
    c.cell_z = 4'(a / 4096);
    c.voxel_value = val;
    send(c);
  endtask

  // writes every unwritten neighbor first so no stale voxel is ever read
  task automatic sample_at(logic [15:0] px, logic [15:0] py, logic [15:0] pz);
    tvs_cmd_t c;
    int a [8];
    c = rand_cmd();
    c.func = FUNC_SAMPLE;
    c.pos_x = px;
    c.pos_y = py;
    c.pos_z = pz;
    sb.corner_addrs(c, a);
    for (int k = 0; k < 8; k++)
      if (!sb.written[a[k]]) write_voxel(a[k], 16'($urandom));
    send(c);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (LAT_WAIT) @(posedge clk);
  endtask

  task automatic set_sizes(logic [6:0] x, logic [6:0] y, logic [6:0] z);
    logic [6:0] vals [3];
    vals = '{x, y, z};
    drain();
    for (int i = 0; i < 3; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= i[1:0];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_size(i[1:0], vals[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_pos(int s);
    if ($urandom_range(2) == 0) return 16'($urandom);
    return 16'($urandom_range((s + 4) * 256) - 1024);
  endfunction

  initial begin
    tvs_cmd_t c;
    logic [6:0] cfgs [8][3];
    sb = new();
    rst = 1'b1;
    push = 1'b0;
    cmd = '0;
    pop = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = CFG_SIZE_X;
    cfg_data = '0;
    send_idle = 0;
    recv_stall = 0;
    quiet_cycles = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extreme values, ties, extreme positions
    write_voxel(0, 16'sd0);
    write_voxel(1, 16'sd1);
    write_voxel((15 * 64 + 63) * 64 + 63, 16'sh7fff);
    write_voxel((14 * 64 + 62) * 64 + 62, 16'sh8000);
    sample_at(16'h0080, 16'h0000, 16'h0000);
    sample_at(16'h0000, 16'h0000, 16'h0000);
    sample_at(16'h7fff, 16'h7fff, 16'h7fff);
    sample_at(16'h8000, 16'h8000, 16'h8000);
    sample_at(16'hffff, 16'h0001, 16'hff80);
    sample_at(16'h3eff, 16'h3eff, 16'h0eff);
    write_voxel($urandom_range(65535), 16'h8000);
    write_voxel($urandom_range(65535), 16'h7fff);
    sample_at(16'h3e80, 16'h3e80, 16'h0e80);

    cfgs = '{'{7'd64, 7'd64, 7'd16}, '{7'd2, 7'd2, 7'd2}, '{7'd0, 7'd1, 7'd0},
             '{7'd127, 7'd127, 7'd31}, '{7'd5, 7'd9, 7'd3},
             '{7'd33, 7'd17, 7'd7}, '{7'd3, 7'd64, 7'd16}, '{7'd64, 7'd2, 7'd2}};
    for (int p = 0; p < 8; p++) begin
      set_sizes(cfgs[p][0], cfgs[p][1], cfgs[p][2]);
      for (int n = 0; n < 28; n++) begin
        case (n / 7)
          0: begin send_idle = 0;  recv_stall = 0;  end
          1: begin send_idle = 51; recv_stall = 0;  end
          2: begin send_idle = 0;  recv_stall = 51; end
          default: begin send_idle = 35; recv_stall = 35; end
        endcase
        if (p == 3 && n == 14) drain();
        if ($urandom_range(99) < 30) begin
          c = rand_cmd();
          c.func = FUNC_WRITE;
          send(c);
        end else begin
          sample_at(rand_pos(cfgs[p][0] > 64 ? 64 : cfgs[p][0]),
                    rand_pos(cfgs[p][1] > 64 ? 64 : cfgs[p][1]),
                    rand_pos(cfgs[p][2] > 16 ? 16 : cfgs[p][2]));
        end
      end
    end
    send_idle = 0;
    recv_stall = 0;
    drain();
    if (sb.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/tvs_pkg.sv
hw/rtl/tvs_ram.sv
hw/rtl/tvs_fifo.sv
hw/rtl/tvs_wrap.sv
hw/rtl/tvs_front.sv
hw/rtl/tvs_back.sv
hw/rtl/trilinear_volume_sample.sv
tb/sv/tb_trilinear_volume_sample.sv
